@@ design/terq_pkg.sv @@
// Shared types and constants for the timed event ring queue.
// Used by terq_ctrl, terq_dp and timed_event_ring_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package terq_pkg;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int DEST_W    = 8;
  localparam int PAYLOAD_W = 16;
  localparam int RES_W     = 2;

  // Default ring depth
  localparam int QUEUE_DEPTH_DEF = 16;

  // Input item kinds
  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  // Result kinds
  localparam logic [RES_W-1:0] RES_ACCEPTED  = 2'd0;
  localparam logic [RES_W-1:0] RES_REJECTED  = 2'd1;
  localparam logic [RES_W-1:0] RES_DELIVERED = 2'd2;
  localparam logic [RES_W-1:0] RES_NONE_DUE  = 2'd3;

  // One stored event
  typedef struct packed {
    logic [TIME_W-1:0]    when;
    logic [DEST_W-1:0]    dest;
    logic [PAYLOAD_W-1:0] handle;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic sched;     // store a scheduled event unless the ring is full, and answer it
    logic tick_load; // start a tick: latch visit count, clear pending delivery
    logic rd;        // read the oldest entry, advance read pointer
    logic requeue;   // write the read entry back at the write end
    logic deliver;   // take the read entry as a delivery
    logic finish;    // emit the final result of a tick, advance time
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;  // ring is empty
    logic visits_zero; // no entry left to visit in this tick
    logic due;         // entry just read is due now
    logic pend_valid;  // a delivery is held back waiting for its last flag
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/timed_event_ring_queue.sv @@
// Timed event ring queue, top level: controller plus datapath.
// Depends on terq_pkg, terq_ctrl and terq_dp.
//
// Usage:
//   Input channel (in_*): valid/ready. in_kind selects schedule (store an
//   event with in_event_time, in_destination, in_payload) or tick (deliver
//   every stored event whose time equals the current time, then advance it).
//   Output channel (out_*): valid/ready, one transaction per result; out_last
//   marks the final result of an input item.
//   Config port: cfg_wr_en with cfg_wr_data loads the current time.
// Operation:
//   A schedule's result is registered and valid in the cycle after
//   acceptance; while out_ready is high a new item can be taken in the
//   following cycle, so schedules then run at one per cycle. A tick reads
//   each stored entry from memory (READ) and evaluates it (EVAL), then
//   emits its final result (FINISH). Each delivery is held until the next
//   due entry or the end of the scan decides its last flag.
// Reset: synchronous, active low; ring empty, pointers and time at zero.
//   Memory contents are not cleared, so reset needs no clearing sequence.
// Stall: a stalled output holds its result. While the output is full, the
//   scan pauses at a further delivery or at the finish, and no new item is taken.
`timescale 1ns / 1ps
`default_nettype none

module timed_event_ring_queue #(
  parameter int QUEUE_DEPTH = terq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_kind,
  input  wire  [terq_pkg::TIME_W-1:0]        in_event_time,
  input  wire  [terq_pkg::DEST_W-1:0]        in_destination,
  input  wire  [terq_pkg::PAYLOAD_W-1:0]     in_payload,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [terq_pkg::RES_W-1:0]         out_result_kind,
  output logic [terq_pkg::DEST_W-1:0]        out_destination,
  output logic [terq_pkg::PAYLOAD_W-1:0]     out_payload,
  output logic [terq_pkg::TIME_W-1:0]        out_time,
  output logic                               out_last,
  input  wire                                cfg_wr_en,
  input  wire  [terq_pkg::TIME_W-1:0]        cfg_wr_data
);

  terq_pkg::ctrl_cmd_t  cmd;
  terq_pkg::dp_status_t sts;

  terq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  terq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_event_time   (in_event_time),
    .in_destination  (in_destination),
    .in_payload      (in_payload),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_destination (out_destination),
    .out_payload     (out_payload),
    .out_time        (out_time),
    .out_last        (out_last)
  );

  // A schedule transaction is answered in the next cycle with a single result
  a_sched_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == terq_pkg::KIND_SCHEDULE)
      |=> (out_valid && out_last))
    else $error("schedule not answered in the next cycle");

  // A tick transaction blocks the input while the scan runs
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == terq_pkg::KIND_TICK) |=> !in_ready)
    else $error("input taken during tick scan");

  // Single-result answers always carry the last flag
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == terq_pkg::RES_ACCEPTED ||
                   out_result_kind == terq_pkg::RES_REJECTED ||
                   out_result_kind == terq_pkg::RES_NONE_DUE)) |-> out_last)
    else $error("single result without last flag");

  // A delivery taken while none is held becomes the held delivery
  a_held_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.deliver && !sts.pend_valid) |=> sts.pend_valid)
    else $error("delivery not held");

endmodule

`default_nettype wire

@@ design/terq_ctrl.sv @@
// Controller state machine for the timed event ring queue.
// Depends on terq_pkg; drives terq_dp through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module terq_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_kind,
  output logic                 in_ready,
  input  terq_pkg::dp_status_t sts,
  output terq_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_EVAL   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_kind == terq_pkg::KIND_SCHEDULE) begin
            cmd.sched = 1'b1;
          end else begin
            cmd.tick_load = 1'b1;
            state_nxt     = sts.count_zero ? ST_FINISH : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.due) begin
          // a held delivery must leave before the new one replaces it
          if (!sts.pend_valid || sts.out_free) begin
            cmd.deliver = 1'b1;
            state_nxt   = sts.visits_zero ? ST_FINISH : ST_READ;
          end
        end else begin
          cmd.requeue = 1'b1;
          state_nxt   = sts.visits_zero ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/terq_dp.sv @@
// Datapath of the timed event ring queue: event memory, pointers, counters,
// current time, held delivery and output register. Depends on terq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module terq_dp #(
  parameter int QUEUE_DEPTH = terq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  terq_pkg::ctrl_cmd_t                cmd,
  output terq_pkg::dp_status_t               sts,
  input  wire  [terq_pkg::TIME_W-1:0]        in_event_time,
  input  wire  [terq_pkg::DEST_W-1:0]        in_destination,
  input  wire  [terq_pkg::PAYLOAD_W-1:0]     in_payload,
  input  wire                                cfg_wr_en,
  input  wire  [terq_pkg::TIME_W-1:0]        cfg_wr_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [terq_pkg::RES_W-1:0]         out_result_kind,
  output logic [terq_pkg::DEST_W-1:0]        out_destination,
  output logic [terq_pkg::PAYLOAD_W-1:0]     out_payload,
  output logic [terq_pkg::TIME_W-1:0]        out_time,
  output logic                               out_last
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  terq_pkg::entry_t mem [QUEUE_DEPTH];
  terq_pkg::entry_t rdata_r;
  terq_pkg::entry_t wdata;
  terq_pkg::entry_t pend_r;
  logic             mem_we;

  logic [PTR_W-1:0]            rp_r;
  logic [PTR_W-1:0]            wp_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic [CNT_W-1:0]            visits_r;
  logic [terq_pkg::TIME_W-1:0] time_r;
  logic                        pend_valid_r;
  logic                        full;
  logic                        sched_store;

  logic                           out_valid_r;
  logic [terq_pkg::RES_W-1:0]     out_kind_r;
  logic [terq_pkg::DEST_W-1:0]    out_dest_r;
  logic [terq_pkg::PAYLOAD_W-1:0] out_pay_r;
  logic [terq_pkg::TIME_W-1:0]    out_time_r;
  logic                           out_last_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign full        = (count_r == CNT_FULL);
  assign sched_store = cmd.sched && !full;

  // Memory write: new event on schedule, read entry on requeue
  assign mem_we = sched_store || cmd.requeue;
  always_comb begin
    if (cmd.sched) begin
      wdata.when   = in_event_time;
      wdata.dest   = in_destination;
      wdata.handle = in_payload;
    end else begin
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rp_r];
    end
  end

  // Entry count: up on a stored schedule, down on a delivery
  always_comb begin
    count_nxt = count_r;
    if (sched_store) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.deliver) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers, counters, time and held delivery
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r         <= '0;
      wp_r         <= '0;
      count_r      <= '0;
      visits_r     <= '0;
      time_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (mem_we) begin
        wp_r <= ptr_inc(wp_r);
      end
      if (cmd.tick_load) begin
        visits_r     <= count_r;
        pend_valid_r <= 1'b0;
      end
      if (cmd.rd) begin
        rp_r     <= ptr_inc(rp_r);
        visits_r <= visits_r - 1'b1;
      end
      if (cmd.deliver) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.finish) begin
        pend_valid_r <= 1'b0;
        time_r       <= time_r + 1'b1;
      end
      if (cfg_wr_en) begin
        time_r <= cfg_wr_data;
      end
    end
  end

  // Held delivery payload
  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      pend_r <= rdata_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sched || cmd.finish || (cmd.deliver && pend_valid_r)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      out_kind_r <= full ? terq_pkg::RES_REJECTED : terq_pkg::RES_ACCEPTED;
      out_dest_r <= '0;
      out_pay_r  <= '0;
      out_time_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.deliver && pend_valid_r) begin
      // a later due entry was found, so the held one is not the last
      out_kind_r <= terq_pkg::RES_DELIVERED;
      out_dest_r <= pend_r.dest;
      out_pay_r  <= pend_r.handle;
      out_time_r <= time_r;
      out_last_r <= 1'b0;
    end else if (cmd.finish) begin
      out_kind_r <= pend_valid_r ? terq_pkg::RES_DELIVERED : terq_pkg::RES_NONE_DUE;
      out_dest_r <= pend_valid_r ? pend_r.dest : '0;
      out_pay_r  <= pend_valid_r ? pend_r.handle : '0;
      out_time_r <= time_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_destination = out_dest_r;
  assign out_payload     = out_pay_r;
  assign out_time        = out_time_r;
  assign out_last        = out_last_r;

  // Status to controller
  assign sts.count_zero  = (count_r == '0);
  assign sts.visits_zero = (visits_r == '0);
  assign sts.due         = (rdata_r.when == time_r);
  assign sts.pend_valid  = pend_valid_r;
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule

`default_nettype wire
